FILE: src/xcfp_pkg.sv
// Shared types and constants for the XOR-checked frame parser.
package xcfp_pkg;

  // Status codes carried by a status result
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_SHORT    = 3'd1;
  localparam logic [2:0] ST_HEADER   = 3'd2;
  localparam logic [2:0] ST_CHECKSUM = 3'd3;
  localparam logic [2:0] ST_LENGTH   = 3'd4;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  // Configuration register indexes
  localparam logic CFG_HEADER_BYTE = 1'b0;
  localparam logic CFG_MAX_LEN     = 1'b1;

  // Reset values of the configuration registers
  localparam logic [7:0]  HEADER_RST  = 8'd170;
  localparam logic [15:0] MAX_LEN_RST = 16'd256;

  // Saturation point of the byte counter
  localparam logic [16:0] COUNT_MAX = 17'h1FFFF;

  // Byte index of the first payload byte (after header, function, length)
  localparam logic [16:0] PAYLOAD_IDX = 17'd4;

  // Record queue between classifier and result sequencer
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       buffer_end;
  } in_t;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  payload_byte;
    logic [2:0]  status;
    logic [7:0]  function_code;
    logic [15:0] payload_length;
    logic        end_of_run;
  } out_t;

  // One classified byte: an optional payload result and an optional status
  typedef struct packed {
    logic        has_pay;
    logic [7:0]  pay_byte;
    logic        has_stat;
    logic [2:0]  status;
    logic [7:0]  func;
    logic [15:0] len;
  } rec_t;

  // Queue status seen by the front and back parts
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

FILE: src/xcfp_front.sv
// Front part: config registers, frame state and per-byte classification.
module xcfp_front
  import xcfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  input  logic        cfg_valid,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  qstat_t      qstat,
  output logic        push,
  output rec_t        push_rec
);

  logic [7:0]  header_r;
  logic [15:0] max_len_r;
  logic [16:0] count_r, count_nxt;
  logic        hdr_bad_r, hdr_bad_nxt;
  logic [7:0]  func_r, func_nxt;
  logic [15:0] len_r, len_nxt;
  logic [7:0]  xor_r, xor_nxt;
  logic        fin_r, fin_nxt;
  logic        accept;
  logic [7:0]  b;
  rec_t        rec;

  assign in_stall = qstat.full;
  assign accept   = in_valid && !in_stall;
  assign b        = in_data.rx_byte;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r  <= HEADER_RST;
      max_len_r <= MAX_LEN_RST;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_HEADER_BYTE) begin
        header_r <= cfg_data[7:0];
      end else begin
        max_len_r <= cfg_data;
      end
    end
  end

  // Classify the incoming byte by its position in the frame
  always_comb begin
    count_nxt   = count_r;
    hdr_bad_nxt = hdr_bad_r;
    func_nxt    = func_r;
    len_nxt     = len_r;
    xor_nxt     = xor_r;
    fin_nxt     = fin_r;
    rec         = '0;
    if (!fin_r) begin
      case (count_r)
        17'd0: hdr_bad_nxt = (b != header_r);
        17'd1: begin
          func_nxt = b;
          xor_nxt  = xor_r ^ b;
        end
        17'd2: begin
          len_nxt  = {len_r[15:8], b};
          xor_nxt  = xor_r ^ b;
        end
        17'd3: begin
          len_nxt  = {b, len_r[7:0]};
          xor_nxt  = xor_r ^ b;
        end
        default: begin
          if (count_r == PAYLOAD_IDX && hdr_bad_r) begin
            rec.has_stat = 1'b1;
            rec.status   = ST_HEADER;
            fin_nxt      = 1'b1;
          end else if (count_r == PAYLOAD_IDX && len_r > max_len_r) begin
            rec.has_stat = 1'b1;
            rec.status   = ST_LENGTH;
            fin_nxt      = 1'b1;
          end else if (count_r == ({1'b0, len_r} + PAYLOAD_IDX)) begin
            rec.has_stat = 1'b1;
            rec.status   = (xor_r == b) ? ST_OK : ST_CHECKSUM;
            fin_nxt      = 1'b1;
          end else begin
            xor_nxt      = xor_r ^ b;
            rec.has_pay  = 1'b1;
            rec.pay_byte = b;
          end
        end
      endcase
    end
    if (count_r != COUNT_MAX) begin
      count_nxt = count_r + 17'd1;
    end
    // Status fields snapshot the values after this byte
    rec.func = func_nxt;
    rec.len  = len_nxt;
    if (in_data.buffer_end) begin
      if (!fin_nxt) begin
        rec.has_stat = 1'b1;
        rec.status   = ST_SHORT;
      end
      count_nxt   = '0;
      hdr_bad_nxt = 1'b0;
      func_nxt    = '0;
      len_nxt     = '0;
      xor_nxt     = '0;
      fin_nxt     = 1'b0;
    end
  end

  // Frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      hdr_bad_r <= 1'b0;
      func_r    <= '0;
      len_r     <= '0;
      xor_r     <= '0;
      fin_r     <= 1'b0;
    end else if (accept) begin
      count_r   <= count_nxt;
      hdr_bad_r <= hdr_bad_nxt;
      func_r    <= func_nxt;
      len_r     <= len_nxt;
      xor_r     <= xor_nxt;
      fin_r     <= fin_nxt;
    end
  end

  assign push     = accept && (rec.has_pay || rec.has_stat);
  assign push_rec = rec;

endmodule

FILE: src/xcfp_queue.sv
// Small record queue in flip-flops between front and back parts.
module xcfp_queue
  import xcfp_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  rec_t   push_rec,
  input  logic   pop,
  output rec_t   head,
  output qstat_t qstat
);

  rec_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign qstat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign qstat.empty = (cnt_r == '0);
  assign head        = mem_r[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!qstat.full || pop))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !qstat.empty)
    else $error("queue pop while empty");

endmodule

FILE: src/xcfp_back.sv
// Back part: expands queued records into results behind an output register.
module xcfp_back
  import xcfp_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  rec_t   head,
  input  qstat_t qstat,
  output logic   pop,
  output logic   out_valid,
  input  logic   out_stall,
  output out_t   out_data
);

  logic out_valid_r;
  out_t out_r, out_nxt;
  logic phase_r, phase_nxt;
  logic emit_stat;
  logic rec_last;
  logic load;

  // Payload result first, then status; phase marks a sent payload
  assign emit_stat = !head.has_pay || phase_r;
  // Record is done once its status goes out, or with a payload that has no status
  assign rec_last  = emit_stat || !head.has_stat;
  assign load      = !qstat.empty && (!out_valid_r || !out_stall);
  assign pop       = load && rec_last;

  always_comb begin
    out_nxt   = '0;
    phase_nxt = phase_r;
    if (emit_stat) begin
      out_nxt.item_kind      = KIND_STATUS;
      out_nxt.status         = head.status;
      out_nxt.function_code  = head.func;
      out_nxt.payload_length = head.len;
      out_nxt.end_of_run     = 1'b1;
    end else begin
      out_nxt.item_kind      = KIND_PAYLOAD;
      out_nxt.payload_byte   = head.pay_byte;
      out_nxt.end_of_run     = !head.has_stat;
    end
    if (load) begin
      phase_nxt = !rec_last;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_phase_has_status: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> (!qstat.empty && head.has_pay && head.has_stat))
    else $error("payload sent but no status pending");

  a_payload_open_run: assert property (@(posedge clk) disable iff (!rst_n)
    (load && !emit_stat && head.has_stat) |=>
      (phase_r && out_valid_r && out_r.item_kind == KIND_PAYLOAD))
    else $error("status did not follow its payload");

endmodule

FILE: src/xor_checked_frame_parser_unit.sv
// Top level of the XOR-checked frame parser: front, record queue, back.
//
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_stall  | in_t  {rx_byte, buffer_end}
//  out_    | output    | out_valid / out_stall| out_t {kind, byte, status, func, len, eor}
//  cfg_    | input     | cfg_valid / cfg_ready| cfg_index (1b), cfg_data (16b)
//
// One byte is accepted per cycle while in_stall is low; a byte's results pass
// through the record queue and then the output register. A byte giving a payload
// byte and a status gives two results in turn from the single output register. The
// 4-entry record queue absorbs that and output stalls; in_stall rises only when full.
// Reset (synchronous, rst_n low) clears frame state, queue and output valid,
// and loads header 0xAA and length limit 256. cfg_ready is always high.
module xor_checked_frame_parser_unit
  import xcfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  qstat_t qstat;
  logic   push;
  logic   pop;
  rec_t   push_rec;
  rec_t   head;

  assign cfg_ready = 1'b1;

  xcfp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .qstat     (qstat),
    .push      (push),
    .push_rec  (push_rec)
  );

  xcfp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  xcfp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .qstat     (qstat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
